// ----- hw/rtl/kwt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwt_pkg - keyword tokenizer shared definitions
// Token kinds, character codes, pending-run modes, the keyword/type table and
// the run flush function.
// ----------------------------------------------------------------------------
package kwt_pkg;

  localparam int KEYWORD_CHARS_DEF = 4;
  localparam int IN_TDATA_W        = 8;
  localparam int OUT_TDATA_W       = 24;
  localparam int WORD_COUNT        = 15;

  typedef enum logic [4:0] {
    TK_PLUS    = 5'd0,
    TK_MINUS   = 5'd1,
    TK_ARROW   = 5'd2,
    TK_STAR    = 5'd3,
    TK_SLASH   = 5'd4,
    TK_LPAREN  = 5'd5,
    TK_RPAREN  = 5'd6,
    TK_EQUAL   = 5'd7,
    TK_SEMI    = 5'd8,
    TK_LCURLY  = 5'd9,
    TK_RCURLY  = 5'd10,
    TK_COLON   = 5'd11,
    TK_COMMA   = 5'd12,
    TK_LITERAL = 5'd13,
    TK_LET     = 5'd14,
    TK_FN      = 5'd15,
    TK_RET     = 5'd16,
    TK_TYPE    = 5'd17,
    TK_IDENT   = 5'd18
  } token_kind_t;

  // pending run state, one-hot
  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_MINUS  = 4'b0010,
    MODE_DIGITS = 4'b0100,
    MODE_WORD   = 4'b1000
  } mode_t;

  // ASCII codes
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;

  // kind in the low bits, so the struct drops straight onto tdata
  typedef struct packed {
    logic [7:0]  len;
    logic [3:0]  idx;
    token_kind_t kind;
  } tok_t;

  typedef struct packed {
    logic v0;
    logic v1;
    tok_t tok0;
    tok_t tok1;
  } step_t;

  // keywords and type names, first char in the low byte
  localparam logic [7:0] WORD_LEN [WORD_COUNT] = '{
    8'd3, 8'd2, 8'd3, 8'd4, 8'd2, 8'd3, 8'd3, 8'd3,
    8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd4
  };
  localparam logic [31:0] WORD_CHARS [WORD_COUNT] = '{
    32'h0074656C, // let
    32'h00006E66, // fn
    32'h00746572, // ret
    32'h6C6F6F62, // bool
    32'h00003875, // u8
    32'h00363175, // u16
    32'h00323375, // u32
    32'h00343675, // u64
    32'h00003869, // i8
    32'h00363169, // i16
    32'h00323369, // i32
    32'h00343669, // i64
    32'h00323366, // f32
    32'h00343666, // f64
    32'h64696F76  // void
  };
  localparam token_kind_t WORD_KIND [WORD_COUNT] = '{
    TK_LET, TK_FN, TK_RET, TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE,
    TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE, TK_TYPE
  };
  localparam logic [3:0] WORD_IDX [WORD_COUNT] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
    4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11
  };

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z]};
  endfunction

  function automatic tok_t make_tok(input token_kind_t kind, input logic [3:0] idx,
                                    input logic [7:0] len);
    tok_t t;
    t.kind = kind;
    t.idx  = idx;
    t.len  = len;
    return t;
  endfunction

  // single-char operators; hit=0 for anything else
  function automatic logic op_lookup(input logic [7:0] c, output token_kind_t kind);
    logic hit;
    hit  = 1'b1;
    kind = TK_PLUS;
    case (c)
      CH_PLUS:   kind = TK_PLUS;
      CH_STAR:   kind = TK_STAR;
      CH_SLASH:  kind = TK_SLASH;
      CH_LPAREN: kind = TK_LPAREN;
      CH_RPAREN: kind = TK_RPAREN;
      CH_EQUAL:  kind = TK_EQUAL;
      CH_SEMI:   kind = TK_SEMI;
      CH_LCURLY: kind = TK_LCURLY;
      CH_RCURLY: kind = TK_RCURLY;
      CH_COLON:  kind = TK_COLON;
      CH_COMMA:  kind = TK_COMMA;
      default:   hit = 1'b0;
    endcase
    return hit;
  endfunction

  // token for whatever is pending; bytes past the run length are zero, so a
  // length match plus a 32-bit compare is an exact word match
  function automatic tok_t flush_tok(input mode_t mode, input logic [7:0] len,
                                     input logic [31:0] lead);
    tok_t t;
    t = make_tok(TK_IDENT, 4'd0, len);
    case (mode)
      MODE_MINUS:  t = make_tok(TK_MINUS, 4'd0, 8'd1);
      MODE_DIGITS: t = make_tok(TK_LITERAL, 4'd0, len);
      MODE_WORD: begin
        for (int i = 0; i < WORD_COUNT; i++) begin
          if (WORD_LEN[i] == len && WORD_CHARS[i] == lead) begin
            t.kind = WORD_KIND[i];
            t.idx  = WORD_IDX[i];
          end
        end
      end
      default:     t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- hw/rtl/kwt_lex.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwt_lex - one-byte lexer step
// Given the pending run and one byte, gives up to two tokens and the next
// pending run. Purely combinational.
// ----------------------------------------------------------------------------
module kwt_lex #(
  parameter int KEYWORD_CHARS = kwt_pkg::KEYWORD_CHARS_DEF,
  localparam int LEAD_W = 8 * KEYWORD_CHARS
) (
  input  logic [7:0]          source_byte,
  input  logic                end_of_source,
  input  kwt_pkg::mode_t      mode,
  input  logic [7:0]          run_length,
  input  logic [LEAD_W-1:0]   leading_chars,
  output kwt_pkg::step_t      step,
  output kwt_pkg::mode_t      mode_next,
  output logic [7:0]          run_length_next,
  output logic [LEAD_W-1:0]   leading_chars_next
);

  logic [LEAD_W-1:0] lead_ext;
  logic [7:0]        len_ext;

  // append byte to the run; only the first KEYWORD_CHARS bytes are kept
  always_comb begin
    lead_ext = leading_chars;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (run_length == 8'(i)) lead_ext[8*i +: 8] = source_byte;
    end
    len_ext = (run_length == 8'hFF) ? run_length : run_length + 8'd1;
  end

  always_comb begin
    kwt_pkg::tok_t       tok_a, tok_b, tok_c;
    logic                emit_a, emit_b, emit_c, consumed, op_hit;
    kwt_pkg::token_kind_t op_kind;
    kwt_pkg::mode_t      mode_m;
    logic [7:0]          len_m;
    logic [LEAD_W-1:0]   lead_m;

    tok_a    = '0;
    tok_b    = '0;
    emit_a   = 1'b0;
    emit_b   = 1'b0;
    consumed = 1'b0;
    mode_m   = mode;
    len_m    = run_length;
    lead_m   = leading_chars;
    op_hit   = kwt_pkg::op_lookup(source_byte, op_kind);

    // continue or close what is pending
    case (mode)
      kwt_pkg::MODE_MINUS: begin
        emit_a = 1'b1;
        if (source_byte == kwt_pkg::CH_GT) begin
          tok_a    = kwt_pkg::make_tok(kwt_pkg::TK_ARROW, 4'd0, 8'd2);
          mode_m   = kwt_pkg::MODE_IDLE;
          consumed = 1'b1;
        end else begin
          tok_a  = kwt_pkg::flush_tok(mode, run_length, leading_chars[31:0]);
          mode_m = kwt_pkg::MODE_IDLE;
          len_m  = '0;
          lead_m = '0;
        end
      end
      kwt_pkg::MODE_DIGITS, kwt_pkg::MODE_WORD: begin
        if (kwt_pkg::is_digit(source_byte) ||
            (mode == kwt_pkg::MODE_WORD && kwt_pkg::is_letter(source_byte))) begin
          len_m    = len_ext;
          lead_m   = lead_ext;
          consumed = 1'b1;
        end else begin
          emit_a = 1'b1;
          tok_a  = kwt_pkg::flush_tok(mode, run_length, leading_chars[31:0]);
          mode_m = kwt_pkg::MODE_IDLE;
          len_m  = '0;
          lead_m = '0;
        end
      end
      default: ;
    endcase

    // byte not absorbed: operator or start of a new run
    if (!consumed) begin
      if (op_hit) begin
        emit_b = 1'b1;
        tok_b  = kwt_pkg::make_tok(op_kind, 4'd0, 8'd1);
      end else if (source_byte == kwt_pkg::CH_MINUS) begin
        mode_m = kwt_pkg::MODE_MINUS;
      end else if (kwt_pkg::is_digit(source_byte)) begin
        mode_m = kwt_pkg::MODE_DIGITS;
        len_m  = 8'd1;
        lead_m = LEAD_W'(source_byte);
      end else if (kwt_pkg::is_letter(source_byte)) begin
        mode_m = kwt_pkg::MODE_WORD;
        len_m  = 8'd1;
        lead_m = LEAD_W'(source_byte);
      end
    end

    // end of source flush
    emit_c = end_of_source && (mode_m != kwt_pkg::MODE_IDLE);
    tok_c  = kwt_pkg::flush_tok(mode_m, len_m, lead_m[31:0]);
    if (end_of_source) begin
      mode_m = kwt_pkg::MODE_IDLE;
      len_m  = '0;
      lead_m = '0;
    end

    step.v0   = emit_a || emit_b || emit_c;
    step.v1   = (emit_a && emit_b) || ((emit_a || emit_b) && emit_c);
    step.tok0 = emit_a ? tok_a : (emit_b ? tok_b : tok_c);
    step.tok1 = (emit_a && emit_b) ? tok_b : tok_c;

    mode_next          = mode_m;
    run_length_next    = len_m;
    leading_chars_next = lead_m;
  end

endmodule

// ----- hw/rtl/keyword_tokenizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_tokenizer - streaming lexical tokenizer
// Turns a byte stream of source text into operator, literal, keyword, type
// and identifier tokens, one byte per cycle while the output queue has room.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one source byte per request in tdata[7:0]; tlast marks the final
//     byte of the source, after which any pending '-' or run is flushed.
//   m_axis: one token per request; tdata = {pad, length, type index, kind},
//     tlast set on the last token caused by a given input byte.
//   Timing: an accepted byte lands in the input register, and its tokens are
//     written from there to the output queue, which m_axis reads, once the
//     queue has room for two tokens.
//   Throughput: one byte per cycle while m_axis_tready is high and each byte
//     yields at most one token. A byte can yield two (flush + operator, or flush
//     at end of source); the output side then drains at one token per cycle and
//     the 4-entry output queue holds off s_axis while under two slots are free.
//   Reset (rst, synchronous): clears the input register, the output queue and
//     the pending run; no tokens are in flight afterwards.
//   Stall: with m_axis_tready low, tokens sit in the queue and the input side
//     keeps taking bytes until the queue is nearly full. s_axis_tready does
//     not depend on m_axis_tready in the same cycle.
// ----------------------------------------------------------------------------
module keyword_tokenizer #(
  parameter int KEYWORD_CHARS = kwt_pkg::KEYWORD_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kwt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] source_byte
  input  logic                            s_axis_tlast,  // end_of_source
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kwt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [4:0] token_kind,
                                                         // [8:5] type_index,
                                                         // [16:9] token_length
  output logic                            m_axis_tlast   // last_of_run
);

  localparam int LEAD_W  = 8 * KEYWORD_CHARS;
  localparam int Q_DEPTH = 4;
  localparam int PTR_W   = $clog2(Q_DEPTH);
  localparam int CNT_W   = $clog2(Q_DEPTH + 1);
  localparam int PAD_W   = kwt_pkg::OUT_TDATA_W - $bits(kwt_pkg::tok_t);

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;

  // pending run
  kwt_pkg::mode_t    mode, mode_next;
  logic [7:0]        run_length, run_length_next;
  logic [LEAD_W-1:0] leading_chars, leading_chars_next;

  kwt_pkg::step_t step;

  // output queue
  kwt_pkg::tok_t q_tok  [Q_DEPTH];
  logic          q_last [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  logic       advance, pop, in_take;
  logic [1:0] push_n;

  kwt_lex #(
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_lex (
    .source_byte        (s1_byte),
    .end_of_source      (s1_eos),
    .mode               (mode),
    .run_length         (run_length),
    .leading_chars      (leading_chars),
    .step               (step),
    .mode_next          (mode_next),
    .run_length_next    (run_length_next),
    .leading_chars_next (leading_chars_next)
  );

  // room for a worst-case pair of tokens, judged on the registered count
  assign advance       = s1_valid && (count <= CNT_W'(Q_DEPTH - 2));
  assign s_axis_tready = !s1_valid || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign push_n        = !advance ? 2'd0 : (step.v1 ? 2'd2 : (step.v0 ? 2'd1 : 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      mode          <= kwt_pkg::MODE_IDLE;
      run_length    <= '0;
      leading_chars <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (s_axis_tready) s1_valid <= s_axis_tvalid;
      if (advance) begin
        mode          <= mode_next;
        run_length    <= run_length_next;
        leading_chars <= leading_chars_next;
      end
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      count  <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // payload: input byte and queue entries
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= s_axis_tdata[7:0];
      s1_eos  <= s_axis_tlast;
    end
    if (advance && step.v0) begin
      q_tok[wr_ptr]  <= step.tok0;
      q_last[wr_ptr] <= !step.v1;
    end
    if (advance && step.v1) begin
      q_tok[wr_ptr + PTR_W'(1)]  <= step.tok1;
      q_last[wr_ptr + PTR_W'(1)] <= 1'b1;
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = {{PAD_W{1'b0}}, q_tok[rd_ptr]};
  assign m_axis_tlast  = q_last[rd_ptr];

endmodule

// ----- hw/rtl/kwt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwt_checker - port-level checks for keyword_tokenizer
// Watches the output stream for handshake rules and token field sanity.
// ----------------------------------------------------------------------------
module kwt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kwt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("m_axis_tvalid dropped under stall");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("m_axis payload changed under stall");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[4:0] <= kwt_pkg::TK_IDENT)
    else $error("token kind out of range");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[16:9] != 8'd0)
    else $error("zero-length token");

  a_type_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4:0] != kwt_pkg::TK_TYPE |-> m_axis_tdata[8:5] == 4'd0)
    else $error("type index set on non-type token");

endmodule

bind keyword_tokenizer kwt_checker u_kwt_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
